// ===== design/adam_pkg.sv =====
// shared constants for the adam optimizer update block
// register indexes, reset values and default widths; no dependencies
package adam_pkg;

    // default datapath format, signed Q16.16
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARNING_RATE     = 3'd0,
        CFG_BETA_FIRST        = 3'd1,
        CFG_BETA_SECOND       = 3'd2,
        CFG_EPSILON_TERM      = 3'd3,
        CFG_DECAY_FACTOR      = 3'd4,
        CFG_FIRST_CORRECTION  = 3'd5,
        CFG_SECOND_CORRECTION = 3'd6
    } t_cfg_idx;

    // register reset values
    localparam logic [15:0] LR_RST     = 16'd66;
    localparam logic [15:0] BETA1_RST  = 16'd58982;
    localparam logic [15:0] BETA2_RST  = 16'd65470;
    localparam logic [15:0] EPS_RST    = 16'd1;
    localparam logic [15:0] DECAY_RST  = 16'd0;
    localparam logic [31:0] FCORR_RST  = 32'd655360;
    localparam logic [31:0] SCORR_RST  = 32'd65536000;

    // the step magnitude is capped at two to this power
    localparam int STEP_CAP_LOG = 40;

endpackage

// ===== design/adam_optimizer_update.sv =====
// adam optimizer update with l2 weight decay, fully pipelined datapath
// depends on adam_pkg for register indexes, reset values and defaults
//
// One parameter update per cycle: a new request is taken every clock while the
// output side keeps up, and a stall on the output freezes the whole pipeline.
// The pipeline has eight multiply/accumulate stages, a square root that settles
// one result bit per stage (SQ_W = 32 stages for Q16.16), and a divider that
// settles one quotient bit per stage over 41 quotient bits, up to the step
// cap. Configuration writes are always taken and must only arrive while no
// request is in flight.
module adam_optimizer_update #(
    parameter int DATA_WIDTH = adam_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = adam_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [adam_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [adam_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input requests
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [DATA_WIDTH-1:0]       i_param_value,
    input  logic signed [DATA_WIDTH-1:0]       i_gradient,
    input  logic signed [DATA_WIDTH-1:0]       i_first_moment,
    input  logic [DATA_WIDTH-2:0]              i_second_moment,
    input  logic                               i_is_weight,
    // results
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [DATA_WIDTH-1:0]       o_new_param,
    output logic signed [DATA_WIDTH-1:0]       o_new_first_moment,
    output logic [DATA_WIDTH-2:0]              o_new_second_moment,
    output logic signed [DATA_WIDTH-1:0]       o_adjusted_gradient
);
    import adam_pkg::*;

    localparam int D      = DATA_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int FW     = (F > 16) ? F : 16;
    localparam int OB_W   = FW + 2;                 // signed one minus beta1
    localparam int OB2_W  = FW + 1;                 // one minus beta2
    localparam int DP_W   = D + 17;                 // decay product
    localparam int MS_W   = D + OB_W + 1;           // first moment sum
    localparam int G2_W   = 2 * D - F;              // squared gradient
    localparam int VP_W   = OB2_W + G2_W;
    localparam int VS_W   = ((VP_W > D + 16) ? VP_W : D + 16) + 1;
    localparam int MH_W   = D + 32 - F;             // corrected first moment
    localparam int VH_W   = D + 31 - F;             // corrected second moment
    localparam int NUM_W  = 16 + MH_W;              // lr times m_hat
    localparam int SQ_W   = (VH_W + F + 1) / 2;     // root width
    localparam int RAD_W  = 2 * SQ_W;
    localparam int RW     = SQ_W + 2;               // root remainder
    localparam int DEN_W  = SQ_W + 1;
    localparam int DR_W   = DEN_W + 1;              // divider remainder
    localparam int QW     = STEP_CAP_LOG + 1;
    localparam int NV_W   = D + QW + 1;
    localparam int NST    = 11 + SQ_W + QW;
    localparam int V_SQ_END = 7 + SQ_W;
    localparam int V_DV_END = 9 + SQ_W + QW;
    localparam logic [QW-1:0] STEP_CAP = QW'(1) << STEP_CAP_LOG;

    typedef struct packed {
        logic signed [D-1:0] value;
        logic signed [D-1:0] grad;
        logic signed [D-1:0] m_new;
        logic [D-2:0]        v_new;
        logic                m_neg;
        logic                mhat_zero;
    } t_pay;

    // configuration registers
    logic [15:0] r_lr, r_beta1, r_beta2, r_eps, r_decay;
    logic [31:0] r_fcorr, r_scorr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr    <= LR_RST;
            r_beta1 <= BETA1_RST;
            r_beta2 <= BETA2_RST;
            r_eps   <= EPS_RST;
            r_decay <= DECAY_RST;
            r_fcorr <= FCORR_RST;
            r_scorr <= SCORR_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LEARNING_RATE:     r_lr    <= i_cfg_data[15:0];
                CFG_BETA_FIRST:        r_beta1 <= i_cfg_data[15:0];
                CFG_BETA_SECOND:       r_beta2 <= i_cfg_data[15:0];
                CFG_EPSILON_TERM:      r_eps   <= i_cfg_data[15:0];
                CFG_DECAY_FACTOR:      r_decay <= i_cfg_data[15:0];
                CFG_FIRST_CORRECTION:  r_fcorr <= i_cfg_data[31:0];
                CFG_SECOND_CORRECTION: r_scorr <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // pipeline advance and valid bits
    logic             w_adv, w_in_acc;
    logic [NST-1:0]   r_vld;

    assign w_adv       = !r_vld[NST-1] || i_out_ready;
    assign o_in_ready  = w_adv;
    assign w_in_acc    = i_in_valid && w_adv;
    assign o_out_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], w_in_acc};
        end
    end

    // stage a: decay product and the two products on stored moments
    logic signed [D-1:0]    r_a_value, r_a_g;
    logic                   r_a_apply;
    logic signed [DP_W-1:0] r_a_dprod, r_a_b1m;
    logic [D+15:0]          r_a_b2v;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_value <= i_param_value;
            r_a_g     <= i_gradient;
            r_a_apply <= i_is_weight && (r_decay != '0);
            r_a_dprod <= DP_W'($signed({1'b0, r_decay})) * DP_W'(i_param_value);
            r_a_b1m   <= DP_W'($signed({1'b0, r_beta1})) * DP_W'(i_first_moment);
            r_a_b2v   <= (D+16)'(r_beta2) * (D+16)'(i_second_moment);
        end
    end

    // stage b: add decay term to gradient, saturate
    logic signed [DP_W:0]   w_gsum;
    logic                   w_gsum_ovf;
    logic signed [D-1:0]    w_gadj;
    logic signed [D-1:0]    r_b_value, r_b_g;
    logic signed [DP_W-1:0] r_b_b1m;
    logic [D+15:0]          r_b_b2v;

    assign w_gsum     = (DP_W+1)'(r_a_dprod >>> F) + (DP_W+1)'(r_a_g);
    assign w_gsum_ovf = !(&w_gsum[DP_W:D-1] || ~|w_gsum[DP_W:D-1]);
    assign w_gadj     = !r_a_apply ? r_a_g :
                        w_gsum_ovf ? {w_gsum[DP_W], {(D-1){~w_gsum[DP_W]}}} : w_gsum[D-1:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_value <= r_a_value;
            r_b_g     <= w_gadj;
            r_b_b1m   <= r_a_b1m;
            r_b_b2v   <= r_a_b2v;
        end
    end

    // stage c: (1 - beta1) * g and gradient magnitude
    logic signed [OB_W-1:0]   w_omb1;
    logic signed [D-1:0]      r_c_value, r_c_g;
    logic signed [DP_W-1:0]   r_c_b1m;
    logic [D+15:0]            r_c_b2v;
    logic signed [D+OB_W-1:0] r_c_omb1g;
    logic [D-1:0]             r_c_gabs;

    assign w_omb1 = $signed(OB_W'(1) << F) - $signed(OB_W'({1'b0, r_beta1}));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_value <= r_b_value;
            r_c_g     <= r_b_g;
            r_c_b1m   <= r_b_b1m;
            r_c_b2v   <= r_b_b2v;
            r_c_omb1g <= (D+OB_W)'(w_omb1) * (D+OB_W)'(r_b_g);
            r_c_gabs  <= r_b_g[D-1] ? $unsigned(-r_b_g) : $unsigned(r_b_g);
        end
    end

    // stage d: new first moment, gradient squared
    logic signed [MS_W-1:0] w_msum, w_msh;
    logic                   w_m_ovf;
    logic signed [D-1:0]    r_d_value, r_d_g, r_d_m;
    logic [D+15:0]          r_d_b2v;
    logic [2*D-1:0]         r_d_sq;

    assign w_msum  = MS_W'(r_c_b1m) + MS_W'(r_c_omb1g);
    assign w_msh   = w_msum >>> F;
    assign w_m_ovf = !(&w_msh[MS_W-1:D-1] || ~|w_msh[MS_W-1:D-1]);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_value <= r_c_value;
            r_d_g     <= r_c_g;
            r_d_b2v   <= r_c_b2v;
            r_d_m     <= w_m_ovf ? {w_msh[MS_W-1], {(D-1){~w_msh[MS_W-1]}}}
                                 : w_msh[D-1:0];
            r_d_sq    <= (2*D)'(r_c_gabs) * (2*D)'(r_c_gabs);
        end
    end

    // stage e: (1 - beta2) * g^2, first moment magnitude
    logic [OB2_W-1:0]    w_omb2;
    logic [G2_W-1:0]     w_g2;
    logic signed [D-1:0] r_e_value, r_e_g, r_e_m;
    logic [D+15:0]       r_e_b2v;
    logic [VP_W-1:0]     r_e_v2;
    logic [D-1:0]        r_e_mabs;
    logic                r_e_mneg;

    assign w_omb2 = (OB2_W'(1) << F) - OB2_W'(r_beta2);
    assign w_g2   = r_d_sq[2*D-1:F];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_value <= r_d_value;
            r_e_g     <= r_d_g;
            r_e_m     <= r_d_m;
            r_e_b2v   <= r_d_b2v;
            r_e_v2    <= VP_W'(w_omb2) * VP_W'(w_g2);
            r_e_mabs  <= r_d_m[D-1] ? $unsigned(-r_d_m) : $unsigned(r_d_m);
            r_e_mneg  <= r_d_m[D-1];
        end
    end

    // stage f: new second moment, m times first correction
    logic [VS_W-1:0]     w_vsum, w_vsh;
    logic signed [D-1:0] r_f_value, r_f_g, r_f_m;
    logic                r_f_mneg;
    logic [D-2:0]        r_f_v;
    logic [D+31:0]       r_f_mfc;

    assign w_vsum = VS_W'(r_e_b2v) + VS_W'(r_e_v2);
    assign w_vsh  = w_vsum >> F;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f_value <= r_e_value;
            r_f_g     <= r_e_g;
            r_f_m     <= r_e_m;
            r_f_mneg  <= r_e_mneg;
            r_f_v     <= (|w_vsh[VS_W-1:D-1]) ? {(D-1){1'b1}} : w_vsh[D-2:0];
            r_f_mfc   <= (D+32)'(r_e_mabs) * (D+32)'(r_fcorr);
        end
    end

    // stage g: v times second correction, m_hat
    t_pay            r_g_pay;
    logic [D+30:0]   r_g_vsc;
    logic [MH_W-1:0] r_g_mhat;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_g_pay.value     <= r_f_value;
            r_g_pay.grad      <= r_f_g;
            r_g_pay.m_new     <= r_f_m;
            r_g_pay.v_new     <= r_f_v;
            r_g_pay.m_neg     <= r_f_mneg;
            r_g_pay.mhat_zero <= 1'b0;
            r_g_vsc           <= (D+31)'(r_f_v) * (D+31)'(r_scorr);
            r_g_mhat          <= r_f_mfc[D+31:F];
        end
    end

    // stage h: v_hat, numerator lr * m_hat
    t_pay             n_h_pay, r_h_pay;
    logic [VH_W-1:0]  r_h_vhat;
    logic [NUM_W-1:0] r_h_num;

    always_comb begin
        n_h_pay           = r_g_pay;
        n_h_pay.mhat_zero = (r_g_mhat == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_h_pay  <= n_h_pay;
            r_h_vhat <= r_g_vsc[D+30:F];
            r_h_num  <= NUM_W'(r_lr) * NUM_W'(r_g_mhat);
        end
    end

    // square root, one result bit per stage
    logic [RW-1:0]    r_sq_rem  [SQ_W];
    logic [SQ_W-1:0]  r_sq_root [SQ_W];
    logic [RAD_W-1:0] r_sq_rad  [SQ_W];
    logic [NUM_W-1:0] r_sq_num  [SQ_W];
    t_pay             r_sq_pay  [SQ_W];

    for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
        logic [RW-1:0]    w_rem_in, w_cur, w_trial;
        logic [SQ_W-1:0]  w_root_in;
        logic [RAD_W-1:0] w_rad_in;
        logic [NUM_W-1:0] w_num_in;
        t_pay             w_pay_in;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = RAD_W'({r_h_vhat, {F{1'b0}}});
            assign w_num_in  = r_h_num;
            assign w_pay_in  = r_h_pay;
        end else begin : g_next
            assign w_rem_in  = r_sq_rem[k-1];
            assign w_root_in = r_sq_root[k-1];
            assign w_rad_in  = r_sq_rad[k-1];
            assign w_num_in  = r_sq_num[k-1];
            assign w_pay_in  = r_sq_pay[k-1];
        end

        // trial subtract of 4*root + 1
        assign w_cur   = {w_rem_in[RW-3:0], w_rad_in[RAD_W-1 -: 2]};
        assign w_trial = {w_root_in, 2'b01};
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sq_rem[k]  <= w_ge ? (w_cur - w_trial) : w_cur;
                r_sq_root[k] <= {w_root_in[SQ_W-2:0], w_ge};
                r_sq_rad[k]  <= w_rad_in << 2;
                r_sq_num[k]  <= w_num_in;
                r_sq_pay[k]  <= w_pay_in;
            end
        end
    end

    // stage j: denominator
    logic [DEN_W-1:0] r_j_den;
    logic [NUM_W-1:0] r_j_num;
    t_pay             r_j_pay;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_j_den <= DEN_W'(r_sq_root[SQ_W-1]) + DEN_W'(r_eps);
            r_j_num <= r_sq_num[SQ_W-1];
            r_j_pay <= r_sq_pay[SQ_W-1];
        end
    end

    // stage k: cap check and divider setup
    logic             r_k_ovf, r_k_zero;
    logic [DR_W-1:0]  r_k_rem;
    logic [DEN_W-1:0] r_k_den;
    logic [QW-1:0]    r_k_nb;
    t_pay             r_k_pay;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_k_ovf  <= ((r_j_num >> QW) >= NUM_W'(r_j_den));
            r_k_zero <= (r_j_den == '0) && r_j_pay.mhat_zero;
            r_k_rem  <= DR_W'(r_j_num >> QW);
            r_k_den  <= r_j_den;
            r_k_nb   <= r_j_num[QW-1:0];
            r_k_pay  <= r_j_pay;
        end
    end

    // restoring divider, one quotient bit per stage
    logic [DR_W-1:0]  r_dv_rem [QW];
    logic [DEN_W-1:0] r_dv_den [QW];
    logic [QW-1:0]    r_dv_nb  [QW];
    logic [QW-1:0]    r_dv_q   [QW];
    logic             r_dv_ovf [QW];
    logic             r_dv_zero[QW];
    t_pay             r_dv_pay [QW];

    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [DR_W-1:0]  w_rem_in, w_cur;
        logic [DEN_W-1:0] w_den_in;
        logic [QW-1:0]    w_nb_in, w_q_in;
        logic             w_ovf_in, w_zero_in, w_ge;
        t_pay             w_pay_in;

        if (j == 0) begin : g_first
            assign w_rem_in  = r_k_rem;
            assign w_den_in  = r_k_den;
            assign w_nb_in   = r_k_nb;
            assign w_q_in    = '0;
            assign w_ovf_in  = r_k_ovf;
            assign w_zero_in = r_k_zero;
            assign w_pay_in  = r_k_pay;
        end else begin : g_next
            assign w_rem_in  = r_dv_rem[j-1];
            assign w_den_in  = r_dv_den[j-1];
            assign w_nb_in   = r_dv_nb[j-1];
            assign w_q_in    = r_dv_q[j-1];
            assign w_ovf_in  = r_dv_ovf[j-1];
            assign w_zero_in = r_dv_zero[j-1];
            assign w_pay_in  = r_dv_pay[j-1];
        end

        assign w_cur = {w_rem_in[DR_W-2:0], w_nb_in[QW-1]};
        assign w_ge  = (w_cur >= DR_W'(w_den_in));

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_rem[j]  <= w_ge ? (w_cur - DR_W'(w_den_in)) : w_cur;
                r_dv_den[j]  <= w_den_in;
                r_dv_nb[j]   <= w_nb_in << 1;
                r_dv_q[j]    <= {w_q_in[QW-2:0], w_ge};
                r_dv_ovf[j]  <= w_ovf_in;
                r_dv_zero[j] <= w_zero_in;
                r_dv_pay[j]  <= w_pay_in;
            end
        end
    end

    // stage l: cap the step, apply it, saturate, output register
    logic [QW-1:0]       w_step;
    logic signed [NV_W-1:0] w_nsum;
    logic                w_n_ovf;
    t_pay                w_lpay;
    logic signed [D-1:0] r_o_param, r_o_m, r_o_g;
    logic [D-2:0]        r_o_v;

    assign w_lpay = r_dv_pay[QW-1];
    assign w_step = r_dv_zero[QW-1] ? '0 :
                    (r_dv_ovf[QW-1] || (r_dv_q[QW-1] > STEP_CAP)) ? STEP_CAP :
                    r_dv_q[QW-1];
    assign w_nsum = w_lpay.m_neg ? (NV_W'(w_lpay.value) + NV_W'($signed({1'b0, w_step})))
                                 : (NV_W'(w_lpay.value) - NV_W'($signed({1'b0, w_step})));
    assign w_n_ovf = !(&w_nsum[NV_W-1:D-1] || ~|w_nsum[NV_W-1:D-1]);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_param <= w_n_ovf ? {w_nsum[NV_W-1], {(D-1){~w_nsum[NV_W-1]}}}
                                 : w_nsum[D-1:0];
            r_o_m     <= w_lpay.m_new;
            r_o_v     <= w_lpay.v_new;
            r_o_g     <= w_lpay.grad;
        end
    end

    assign o_new_param         = r_o_param;
    assign o_new_first_moment  = r_o_m;
    assign o_new_second_moment = r_o_v;
    assign o_adjusted_gradient = r_o_g;

`ifndef NO_ASSERTIONS
    // a stall freezes every valid bit in the pipeline
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> $stable(r_vld))
        else $error("pipeline moved during output stall");

    // root remainder never exceeds twice the root
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[V_SQ_END] |-> (r_sq_rem[SQ_W-1] <= RW'({r_sq_root[SQ_W-1], 1'b0})))
        else $error("square root remainder out of range");

    // divider remainder stays below the denominator when no cap applies
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[V_DV_END] && !r_dv_ovf[QW-1]) |->
            (r_dv_rem[QW-1] < DR_W'(r_dv_den[QW-1])))
        else $error("divider remainder out of range");
`endif

endmodule
